FILE: src/gamma_lut_gain_offset_macros.svh
// Assertion macros shared by the gamma block
`ifndef GAMMA_LUT_GAIN_OFFSET_MACROS_SVH
`define GAMMA_LUT_GAIN_OFFSET_MACROS_SVH

// same-cycle implication
`define GLGO_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("glgo assertion failed");

// next-cycle implication
`define GLGO_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("glgo assertion failed");

`endif

FILE: src/glgo_pkg.sv
// Types and constants of the gamma lookup block
package glgo_pkg;

  localparam int CH_BITS        = 16;
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int OFFSET_BITS    = 17;
  localparam int SCALED_BITS    = CH_BITS + GAIN_BITS - GAIN_FRAC_BITS;
  localparam int SUM_BITS       = SCALED_BITS + 2;
  localparam int INDEX_SPAN     = 32'h10000;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

  typedef logic [CH_BITS-1:0] sample_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_GAIN   = 1'b0,
    CFG_OFFSET = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    sample_t r;
    sample_t g;
    sample_t b;
  } rgb_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } ctrl_t;

endpackage

FILE: src/glgo_if.sv
// Request channel interfaces of the gamma lookup block
interface glgo_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] table_index;
  logic [15:0] table_value;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;

  modport source (output valid, command, table_index, table_value, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, command, table_index, table_value, red_in, green_in, blue_in,
                output ready);
endinterface

interface glgo_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: src/gamma_lut_gain_offset.sv
// Top level: gamma curve lookup with gain and offset, three-stage pipeline
//
// Requests arrive on "pixels". command CMD_LOAD writes table_value into the
// curve table at table_index and yields no result; command CMD_PIXEL looks
// up each of the three samples, multiplies by gain (Q4.12, truncated), adds
// the signed offset and saturates. Results leave on "results".
// Table entries must be loaded before any pixel reads them.
// A pixel request passes the table read, the multiply and the add/saturate
// stage into the output register, each of them registered.
// Throughput: one request per cycle while the receiver takes results; each
// stage has its own valid bit and advances when the stage after it is empty
// or moving, so bubbles close up. A stalled receiver freezes only the full
// stages behind the output; the input stays ready while an empty stage
// remains. Gain and offset are written through wr_en/wr_index/wr_data; the
// user must do so only while idle, which the block does not enforce.
// Reset clears the valid bits and sets gain to unity and offset to zero;
// the table contents are undefined until loaded. No clearing pass.
`include "gamma_lut_gain_offset_macros.svh"

module gamma_lut_gain_offset #(
  parameter int TABLE_ENTRIES = 65536,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  glgo_in_if.sink                          pixels,
  glgo_out_if.source                       results,
  input  logic                             wr_en,
  input  glgo_pkg::cfg_reg_t               wr_index,
  input  logic [glgo_pkg::OFFSET_BITS-1:0] wr_data
);
  import glgo_pkg::*;

  logic [GAIN_BITS-1:0]          gain;
  logic signed [OFFSET_BITS-1:0] offset;
  logic                          v1;
  logic                          v2;
  logic                          v3;
  ctrl_t                         ctrl;
  rgb_t                          samples;
  rgb_t                          entries;
  rgb_t                          result;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      offset <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_GAIN:   gain   <= wr_data[GAIN_BITS-1:0];
        CFG_OFFSET: offset <= $signed(wr_data);
        default:    ;
      endcase
    end
  end

  always_comb begin
    ctrl.en3 = !v3 || results.ready;
    ctrl.en2 = !v2 || ctrl.en3;
    ctrl.en1 = !v1 || ctrl.en2;
  end

  assign pixels.ready = ctrl.en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ctrl.en1) begin
        v1 <= pixels.valid && (pixels.command == CMD_PIXEL);
      end
      if (ctrl.en2) begin
        v2 <= v1;
      end
      if (ctrl.en3) begin
        v3 <= v2;
      end
    end
  end

  assign samples = '{r: pixels.red_in, g: pixels.green_in, b: pixels.blue_in};

  glgo_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES), .SAMPLE_BITS(SAMPLE_BITS)) u_lookup (
    .clk         (clk),
    .ctrl        (ctrl),
    .load        (pixels.valid && (pixels.command == CMD_LOAD)),
    .table_index (pixels.table_index),
    .table_value (pixels.table_value),
    .samples     (samples),
    .entries     (entries)
  );

  glgo_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
    .clk     (clk),
    .ctrl    (ctrl),
    .entries (entries),
    .gain    (gain),
    .offset  (offset),
    .result  (result)
  );

  assign results.valid     = v3;
  assign results.red_out   = result.r;
  assign results.green_out = result.g;
  assign results.blue_out  = result.b;

  `GLGO_ASSERT_NEXT(a_load_no_result, clk, rst, pixels.valid && pixels.ready && pixels.command == CMD_LOAD, !v1)
  `GLGO_ASSERT_NEXT(a_pixel_enters, clk, rst, pixels.valid && pixels.ready && pixels.command == CMD_PIXEL, v1)
  `GLGO_ASSERT_NEXT(a_s1_held, clk, rst, v1 && !ctrl.en2, v1)
  `GLGO_ASSERT_NEXT(a_s2_held, clk, rst, v2 && !ctrl.en3, v2 && v3)
  `GLGO_ASSERT_SAME(a_full_stall, clk, rst, v1 && v2 && v3 && !results.ready, !pixels.ready)

endmodule

FILE: src/glgo_ram.sv
// Generic single-write, single-read RAM with registered read
module glgo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/glgo_lookup.sv
// Curve table: three read copies, one per channel, written together by loads
module glgo_lookup #(
  parameter int TABLE_ENTRIES = 65536,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic            clk,
  input  glgo_pkg::ctrl_t ctrl,
  input  logic            load,
  input  logic [15:0]     table_index,
  input  logic [15:0]     table_value,
  input  glgo_pkg::rgb_t  samples,
  output glgo_pkg::rgb_t  entries
);
  import glgo_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [CH_BITS:0] ENTRIES = (CH_BITS + 1)'(TABLE_ENTRIES);
  localparam sample_t SAMPLE_MASK = CH_BITS'((INDEX_SPAN >> (CH_BITS - SAMPLE_BITS)) - 1);

  function automatic logic [AW-1:0] clamp_index(input sample_t s);
    logic [CH_BITS:0] m;
    m = {1'b0, s & SAMPLE_MASK};
    if (m >= ENTRIES) begin
      clamp_index = AW'(TABLE_ENTRIES - 1);
    end else begin
      clamp_index = m[AW-1:0];
    end
  endfunction

  logic          we;
  logic [AW-1:0] waddr;

  // loads outside the table are dropped
  assign we    = ctrl.en1 && load && ({1'b0, table_index} < ENTRIES);
  assign waddr = table_index[AW-1:0];

  glgo_ram #(.WIDTH(CH_BITS), .DEPTH(TABLE_ENTRIES)) u_ram_r (
    .clk(clk), .we(we), .waddr(waddr), .wdata(table_value),
    .re(ctrl.en1), .raddr(clamp_index(samples.r)), .rdata(entries.r)
  );

  glgo_ram #(.WIDTH(CH_BITS), .DEPTH(TABLE_ENTRIES)) u_ram_g (
    .clk(clk), .we(we), .waddr(waddr), .wdata(table_value),
    .re(ctrl.en1), .raddr(clamp_index(samples.g)), .rdata(entries.g)
  );

  glgo_ram #(.WIDTH(CH_BITS), .DEPTH(TABLE_ENTRIES)) u_ram_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(table_value),
    .re(ctrl.en1), .raddr(clamp_index(samples.b)), .rdata(entries.b)
  );

endmodule

FILE: src/glgo_scale.sv
// Gain multiply stage, then offset add and saturation into the output register
module glgo_scale #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  glgo_pkg::ctrl_t                     ctrl,
  input  glgo_pkg::rgb_t                      entries,
  input  logic [glgo_pkg::GAIN_BITS-1:0]      gain,
  input  logic signed [glgo_pkg::OFFSET_BITS-1:0] offset,
  output glgo_pkg::rgb_t                      result
);
  import glgo_pkg::*;

  localparam sample_t SAMPLE_MAX = CH_BITS'((INDEX_SPAN >> (CH_BITS - SAMPLE_BITS)) - 1);
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = $signed(SUM_BITS'(SAMPLE_MAX));

  function automatic logic [SCALED_BITS-1:0] scale(input sample_t e,
                                                   input logic [GAIN_BITS-1:0] g);
    logic [CH_BITS+GAIN_BITS-1:0] p;
    p = e * g;
    scale = p[CH_BITS+GAIN_BITS-1:GAIN_FRAC_BITS];
  endfunction

  function automatic sample_t offset_sat(input logic [SCALED_BITS-1:0] v,
                                         input logic signed [OFFSET_BITS-1:0] o);
    logic signed [SUM_BITS-1:0] s;
    s = $signed({2'b00, v}) + SUM_BITS'(o);
    if (s < 0) begin
      offset_sat = '0;
    end else if (s > SUM_MAX) begin
      offset_sat = SAMPLE_MAX;
    end else begin
      offset_sat = s[CH_BITS-1:0];
    end
  endfunction

  logic [SCALED_BITS-1:0] scaled_r;
  logic [SCALED_BITS-1:0] scaled_g;
  logic [SCALED_BITS-1:0] scaled_b;

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      scaled_r <= scale(entries.r, gain);
      scaled_g <= scale(entries.g, gain);
      scaled_b <= scale(entries.b, gain);
    end
    if (ctrl.en3) begin
      result.r <= offset_sat(scaled_r, offset);
      result.g <= offset_sat(scaled_g, offset);
      result.b <= offset_sat(scaled_b, offset);
    end
  end

endmodule
